FILE: design/ckco_pkg.sv
// Shared types and constants for the colour-keyed cursor overlay.
package ckco_pkg;

   localparam int CURSOR_W   = 32;
   localparam int CURSOR_H   = 32;
   localparam int COORD_BITS = 12;

   localparam int IMG_DEPTH = 1024;
   localparam int IMG_AW    = 10;
   localparam int RGB_BITS  = 24;
   localparam int PIX_BITS  = 32;
   localparam int HOT_BITS  = 5;
   localparam int CSR_BITS  = 12;
   localparam int CSR_IDX_BITS = 3;

   // rectangle edges are signed, one bit wider than a coordinate
   localparam int RECT_BITS = COORD_BITS + 1;
   // working width for edge arithmetic before clipping
   localparam int EDGE_BITS = COORD_BITS + 2;

   localparam logic [RGB_BITS-1:0] COLOUR_KEY = 24'hFF00FF;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_MOVE  = 2'd1,
      CMD_PIXEL = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_565  = 2'd0,
      MODE_555  = 2'd1,
      MODE_BGR  = 2'd2,
      MODE_BGRX = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HOTSPOT_X     = 3'd0,
      CSR_HOTSPOT_Y     = 3'd1,
      CSR_WINDOW_LEFT   = 3'd2,
      CSR_WINDOW_TOP    = 3'd3,
      CSR_WINDOW_RIGHT  = 3'd4,
      CSR_WINDOW_BOTTOM = 3'd5,
      CSR_PIXEL_MODE    = 3'd6,
      CSR_CURSOR_ENABLE = 3'd7
   } csr_idx_type;

endpackage

FILE: design/ckco_ram.sv
// Generic simple dual-port RAM with registered read.
module ckco_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/color_keyed_cursor_overlay.sv
// Colour-keyed cursor overlay: takes one word per clock unless stalled and returns one result
// word per input word (input register, cursor-image RAM read, result register); the registered
// read of the 1024 x 24 image RAM sets the stage split. Load words write the image, move words
// reposition the clipped cursor rectangle while enabled, pixel words return the background or
// the cursor colour in the current pixel format. The pipeline advances whenever the result
// register is free or being taken, so rsp_stall propagates straight back to req_stall.
module color_keyed_cursor_overlay (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic [ckco_pkg::COORD_BITS-1:0]       req_pos_x,
   input  logic [ckco_pkg::COORD_BITS-1:0]       req_pos_y,
   input  logic [ckco_pkg::IMG_AW-1:0]           req_image_index,
   input  logic [ckco_pkg::RGB_BITS-1:0]         req_image_rgb,
   input  logic [ckco_pkg::PIX_BITS-1:0]         req_background,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ckco_pkg::PIX_BITS-1:0]         rsp_pixel_out,
   output logic                                  rsp_cursor_drawn,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ckco_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ckco_pkg::CSR_BITS-1:0]         csr_data
);
   import ckco_pkg::*;

   localparam int COL_BITS = (CURSOR_W > 1) ? $clog2(CURSOR_W) : 1;
   localparam int ROW_BITS = (CURSOR_H > 1) ? $clog2(CURSOR_H) : 1;

   function automatic logic [PIX_BITS-1:0] convert_colour(
      input mode_type               mode,
      input logic [RGB_BITS-1:0]    rgb,
      input logic [PIX_BITS-1:0]    bg
   );
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [PIX_BITS-1:0] res;
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      case (mode)
         MODE_565: res = {16'h0, r[7:3], g[7:2], b[7:3]};
         MODE_555: res = {17'h0, r[7:3], g[7:3], b[7:3]};
         MODE_BGR: res = {8'h0, r, g, b};
         default:  res = {bg[31:24], r, g, b};
      endcase
      return res;
   endfunction

   // configuration
   logic [HOT_BITS-1:0]   hotspot_x_ff, hotspot_y_ff;
   logic [COORD_BITS-1:0] window_left_ff, window_top_ff, window_right_ff, window_bottom_ff;
   mode_type              pixel_mode_ff;
   logic                  cursor_enable_ff;

   // cursor rectangle
   logic signed [RECT_BITS-1:0] rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;
   logic signed [RECT_BITS-1:0] rect_left_in, rect_top_in, rect_right_in, rect_bottom_in;

   // stage 1: input register
   logic                  v1_ff;
   cmd_type               cmd1_ff;
   logic [COORD_BITS-1:0] px1_ff, py1_ff;
   logic [IMG_AW-1:0]     idx1_ff;
   logic [RGB_BITS-1:0]   rgb1_ff;
   logic [PIX_BITS-1:0]   bg1_ff;

   // stage 2: image read in flight
   logic                  v2_ff;
   cmd_type               cmd2_ff;
   logic                  hit2_ff;
   logic [PIX_BITS-1:0]   bg2_ff;

   // stage 3: result register
   logic                  v3_ff;
   cmd_type               cmd3_ff;
   logic [PIX_BITS-1:0]   pixel3_ff, pixel3_in;
   logic                  drawn3_ff, drawn3_in;

   logic adv1, adv2, adv3;

   // move arithmetic
   logic [COORD_BITS-1:0]        cx, cy;
   logic signed [EDGE_BITS-1:0]  l_e, t_e, r_e, b_e, lim_x, lim_y;

   // hit test
   logic signed [RECT_BITS-1:0]  pxs, pys, col_s, row_s;
   logic                         hit1;
   logic [IMG_AW-1:0]            rd_addr;
   logic [RGB_BITS-1:0]          img_rgb;

   // handshake
   assign adv3      = v2_ff && (!v3_ff || !rsp_stall);
   assign adv2      = v1_ff && (!v2_ff || adv3);
   assign req_stall = v1_ff && !adv2;
   assign adv1      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hotspot_x_ff     <= '0;
         hotspot_y_ff     <= '0;
         window_left_ff   <= '0;
         window_top_ff    <= '0;
         window_right_ff  <= COORD_BITS'(640);
         window_bottom_ff <= COORD_BITS'(480);
         pixel_mode_ff    <= MODE_BGRX;
         cursor_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HOTSPOT_X:     hotspot_x_ff     <= csr_data[HOT_BITS-1:0];
            CSR_HOTSPOT_Y:     hotspot_y_ff     <= csr_data[HOT_BITS-1:0];
            CSR_WINDOW_LEFT:   window_left_ff   <= csr_data[COORD_BITS-1:0];
            CSR_WINDOW_TOP:    window_top_ff    <= csr_data[COORD_BITS-1:0];
            CSR_WINDOW_RIGHT:  window_right_ff  <= csr_data[COORD_BITS-1:0];
            CSR_WINDOW_BOTTOM: window_bottom_ff <= csr_data[COORD_BITS-1:0];
            CSR_PIXEL_MODE:    pixel_mode_ff    <= mode_type'(csr_data[1:0]);
            CSR_CURSOR_ENABLE: cursor_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pointer clamp, hotspot offset and clip to limit minus one
   always_comb begin
      if (px1_ff < window_left_ff)        cx = window_left_ff;
      else if (px1_ff >= window_right_ff) cx = window_right_ff;
      else                                cx = px1_ff;
      if (py1_ff < window_top_ff)          cy = window_top_ff;
      else if (py1_ff >= window_bottom_ff) cy = window_bottom_ff;
      else                                 cy = py1_ff;

      l_e   = EDGE_BITS'(cx) - EDGE_BITS'(hotspot_x_ff);
      t_e   = EDGE_BITS'(cy) - EDGE_BITS'(hotspot_y_ff);
      r_e   = l_e + EDGE_BITS'(CURSOR_W);
      b_e   = t_e + EDGE_BITS'(CURSOR_H);
      lim_x = EDGE_BITS'(window_right_ff) - EDGE_BITS'(1);
      lim_y = EDGE_BITS'(window_bottom_ff) - EDGE_BITS'(1);

      rect_left_in   = RECT_BITS'((l_e >= lim_x) ? lim_x : l_e);
      rect_top_in    = RECT_BITS'((t_e >= lim_y) ? lim_y : t_e);
      rect_right_in  = RECT_BITS'((r_e >= lim_x) ? lim_x : r_e);
      rect_bottom_in = RECT_BITS'((b_e >= lim_y) ? lim_y : b_e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_right_ff  <= RECT_BITS'(CURSOR_W);
         rect_bottom_ff <= RECT_BITS'(CURSOR_H);
      end else if (adv2 && cmd1_ff == CMD_MOVE && cursor_enable_ff) begin
         rect_left_ff   <= rect_left_in;
         rect_top_ff    <= rect_top_in;
         rect_right_ff  <= rect_right_in;
         rect_bottom_ff <= rect_bottom_in;
      end
   end

   // hit test against the rectangle; pixels on the window's left/top edge are excluded
   always_comb begin
      pxs   = RECT_BITS'(px1_ff);
      pys   = RECT_BITS'(py1_ff);
      col_s = pxs - rect_left_ff;
      row_s = pys - rect_top_ff;
      hit1  = cursor_enable_ff
              && pxs >= rect_left_ff && pxs < rect_right_ff
              && pys >= rect_top_ff  && pys < rect_bottom_ff
              && px1_ff > window_left_ff && py1_ff > window_top_ff;
      rd_addr = IMG_AW'(int'(row_s[ROW_BITS-1:0]) * CURSOR_W + int'(col_s[COL_BITS-1:0]));
   end

   ckco_ram #(
      .WIDTH (RGB_BITS),
      .DEPTH (IMG_DEPTH)
   ) u_image (
      .clock   (clock),
      .wr_en   (adv2 && cmd1_ff == CMD_LOAD),
      .wr_addr (idx1_ff),
      .wr_data (rgb1_ff),
      .rd_en   (adv2),
      .rd_addr (rd_addr),
      .rd_data (img_rgb)
   );

   always_comb begin
      pixel3_in = '0;
      drawn3_in = 1'b0;
      if (cmd2_ff == CMD_PIXEL) begin
         pixel3_in = bg2_ff;
         if (hit2_ff && img_rgb != COLOUR_KEY) begin
            pixel3_in = convert_colour(pixel_mode_ff, img_rgb, bg2_ff);
            drawn3_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1)            v1_ff <= 1'b1;
         else if (adv2)       v1_ff <= 1'b0;
         if (adv2)            v2_ff <= 1'b1;
         else if (adv3)       v2_ff <= 1'b0;
         if (adv3)            v3_ff <= 1'b1;
         else if (!rsp_stall) v3_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         cmd1_ff <= cmd_type'(req_command);
         px1_ff  <= req_pos_x;
         py1_ff  <= req_pos_y;
         idx1_ff <= req_image_index;
         rgb1_ff <= req_image_rgb;
         bg1_ff  <= req_background;
      end
      if (adv2) begin
         cmd2_ff <= cmd1_ff;
         hit2_ff <= hit1;
         bg2_ff  <= bg1_ff;
      end
      if (adv3) begin
         cmd3_ff   <= cmd2_ff;
         pixel3_ff <= pixel3_in;
         drawn3_ff <= drawn3_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_pixel_out    = pixel3_ff;
   assign rsp_cursor_drawn = drawn3_ff;

   // a word waiting in stage 2 is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !adv3 |-> !adv2)
      else $error("stage 2 overwritten while held");

   // an empty input stage always takes a word
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("input stalled with empty stage 1");

   // only pixel words produce a non-zero result
   a_non_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      v3_ff && cmd3_ff != CMD_PIXEL |-> rsp_pixel_out == '0 && !rsp_cursor_drawn)
      else $error("non-pixel word gave a non-zero result");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the colour-keyed cursor overlay: predictor, stimulus and checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ckco_pkg::*;

   localparam int PIPE_LATENCY = 3;
   localparam int HOLD_CYCLES  = 160;
   localparam int IDLE_LIMIT   = 1000;
   localparam int FILL_WORDS   = 128;

   typedef struct {
      cmd_type                command;
      logic [COORD_BITS-1:0]  pos_x;
      logic [COORD_BITS-1:0]  pos_y;
      logic [IMG_AW-1:0]      index;
      logic [RGB_BITS-1:0]    rgb;
      logic [PIX_BITS-1:0]    background;
   } req_word_type;

   typedef struct {
      logic [PIX_BITS-1:0] pixel;
      logic                drawn;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_command = CMD_NONE;
   logic [COORD_BITS-1:0]   req_pos_x = '0;
   logic [COORD_BITS-1:0]   req_pos_y = '0;
   logic [IMG_AW-1:0]       req_image_index = '0;
   logic [RGB_BITS-1:0]     req_image_rgb = '0;
   logic [PIX_BITS-1:0]     req_background = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [PIX_BITS-1:0]     rsp_pixel_out;
   logic                    rsp_cursor_drawn;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]     csr_data = '0;

   color_keyed_cursor_overlay dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_image_index  (req_image_index),
      .req_image_rgb    (req_image_rgb),
      .req_background   (req_background),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_cursor_drawn (rsp_cursor_drawn),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // overlay state as the block should hold it
   logic [RGB_BITS-1:0]         image_mem [IMG_DEPTH];
   bit                          loaded [IMG_DEPTH];
   logic signed [RECT_BITS-1:0] rect_l = '0;
   logic signed [RECT_BITS-1:0] rect_t = '0;
   logic signed [RECT_BITS-1:0] rect_r = RECT_BITS'(CURSOR_W);
   logic signed [RECT_BITS-1:0] rect_b = RECT_BITS'(CURSOR_H);
   logic [HOT_BITS-1:0]         hot_x = '0;
   logic [HOT_BITS-1:0]         hot_y = '0;
   logic [COORD_BITS-1:0]       win_l = '0;
   logic [COORD_BITS-1:0]       win_t = '0;
   logic [COORD_BITS-1:0]       win_r = COORD_BITS'(640);
   logic [COORD_BITS-1:0]       win_b = COORD_BITS'(480);
   mode_type                    pix_mode = MODE_BGRX;
   logic                        draw_en = 1'b1;

   rsp_word_type expected_rsp [$];
   int fails = 0;
   int words_sent = 0;
   int words_drawn = 0;
   int csr_writes = 0;
   int burst_left = 0;
   int gap_max = 0;

   logic hold_ask = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   stall_pct = 0;
   int   stall_span = 0;

   function automatic logic [PIX_BITS-1:0] to_pixel_format(input logic [RGB_BITS-1:0] rgb,
                                                           input logic [PIX_BITS-1:0] bg);
      logic [7:0] r, g, b;
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      case (pix_mode)
         MODE_565: return {16'b0, r[7:3], g[7:2], b[7:3]};
         MODE_555: return {17'b0, r[7:3], g[7:3], b[7:3]};
         MODE_BGR: return {8'b0, r, g, b};
         default:  return {bg[31:24], r, g, b};
      endcase
   endfunction

   function automatic int clip_to(input int e, input int lim);
      return (e >= lim - 1) ? lim - 1 : e;
   endfunction

   // image word a pixel word would look up, and whether it lands on the cursor at all
   function automatic bit cursor_lookup(input req_word_type w, output int idx);
      int px, py, rl, rt;
      px = int'(w.pos_x);
      py = int'(w.pos_y);
      rl = int'(rect_l);
      rt = int'(rect_t);
      idx = ((py - rt) * CURSOR_W + (px - rl)) & (IMG_DEPTH - 1);
      return draw_en && px >= rl && px < int'(rect_r) && py >= rt && py < int'(rect_b)
             && px > int'(win_l) && py > int'(win_t);
   endfunction

   function automatic rsp_word_type overlay_step(input req_word_type w);
      rsp_word_type res;
      int px, py, wl, wt, wr, wb, cx, cy, l, t, rl, rt, rr, rb;
      logic [RGB_BITS-1:0] rgb;
      res.pixel = '0;
      res.drawn = 1'b0;
      px = int'(w.pos_x);
      py = int'(w.pos_y);
      wl = int'(win_l);
      wt = int'(win_t);
      wr = int'(win_r);
      wb = int'(win_b);
      rl = int'(rect_l);
      rt = int'(rect_t);
      rr = int'(rect_r);
      rb = int'(rect_b);
      case (w.command)
         CMD_LOAD: begin
            image_mem[w.index] = w.rgb;
            loaded[w.index] = 1'b1;
         end
         CMD_MOVE: begin
            if (draw_en) begin
               // pointer clamps to the edge itself, the rectangle to edge minus one
               cx = (px < wl) ? wl : ((px >= wr) ? wr : px);
               cy = (py < wt) ? wt : ((py >= wb) ? wb : py);
               l = cx - int'(hot_x);
               t = cy - int'(hot_y);
               rect_l = RECT_BITS'(clip_to(l, wr));
               rect_t = RECT_BITS'(clip_to(t, wb));
               rect_r = RECT_BITS'(clip_to(l + CURSOR_W, wr));
               rect_b = RECT_BITS'(clip_to(t + CURSOR_H, wb));
            end
         end
         CMD_PIXEL: begin
            res.pixel = w.background;
            if (draw_en && px >= rl && px < rr && py >= rt && py < rb && px > wl && py > wt)
            begin
               rgb = image_mem[IMG_AW'((py - rt) * CURSOR_W + (px - rl))];
               if (rgb != COLOUR_KEY) begin
                  res.pixel = to_pixel_format(rgb, w.background);
                  res.drawn = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_word_type make_word(input cmd_type cmd, input int x, input int y,
                                              input int idx, input logic [RGB_BITS-1:0] rgb,
                                              input logic [PIX_BITS-1:0] bg);
      req_word_type w;
      w.command = cmd;
      w.pos_x = COORD_BITS'(x);
      w.pos_y = COORD_BITS'(y);
      w.index = IMG_AW'(idx);
      w.rgb = rgb;
      w.background = bg;
      return w;
   endfunction

   function automatic logic [RGB_BITS-1:0] random_colour();
      case ($urandom_range(0, 7))
         0, 1:    return COLOUR_KEY;
         2:       return '0;
         3:       return '1;
         default: return RGB_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pointer_coord(input int lo, input int hi);
      case ($urandom_range(0, 5))
         0:       return COORD_BITS'($urandom);
         1:       return COORD_BITS'(lo);
         2:       return COORD_BITS'(hi);
         3:       return COORD_BITS'(hi - 1);
         default: return COORD_BITS'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] near_edge(input int e);
      int v;
      v = e + int'($urandom_range(0, 37)) - 3;
      if (v < 0) v = $urandom_range(0, 3);
      if (v > 4095) v = 4095;
      return COORD_BITS'(v);
   endfunction

   // mostly pixels around the current cursor, with moves, loads and empty commands mixed in;
   // a pixel that would hit a word not yet loaded becomes a load of that word
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      int slot;
      w = make_word(CMD_PIXEL, $urandom, $urandom, $urandom, random_colour(), $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         w.command = CMD_LOAD;
      end else if (pick < 25) begin
         w.command = CMD_MOVE;
         w.pos_x = pointer_coord(int'(win_l), int'(win_r));
         w.pos_y = pointer_coord(int'(win_t), int'(win_b));
      end else if (pick < 30) begin
         w.command = CMD_NONE;
      end else if ($urandom_range(0, 4) != 0) begin
         w.pos_x = near_edge(int'(rect_l));
         w.pos_y = near_edge(int'(rect_t));
      end
      if (w.command == CMD_PIXEL && cursor_lookup(w, slot) && !loaded[slot]) begin
         w.command = CMD_LOAD;
         w.index = IMG_AW'(slot);
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      rsp_word_type want;
      int gap;
      req_valid <= 1'b1;
      req_command <= w.command;
      req_pos_x <= w.pos_x;
      req_pos_y <= w.pos_y;
      req_image_index <= w.index;
      req_image_rgb <= w.rgb;
      req_background <= w.background;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = overlay_step(w);
      expected_rsp.push_back(want);
      words_sent++;
      if (want.drawn) words_drawn++;
      if (gap_max > 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // wait for every outstanding word to come back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_BITS-1:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_HOTSPOT_X:     hot_x = data[HOT_BITS-1:0];
         CSR_HOTSPOT_Y:     hot_y = data[HOT_BITS-1:0];
         CSR_WINDOW_LEFT:   win_l = data;
         CSR_WINDOW_TOP:    win_t = data;
         CSR_WINDOW_RIGHT:  win_r = data;
         CSR_WINDOW_BOTTOM: win_b = data;
         CSR_PIXEL_MODE:    pix_mode = mode_type'(data[1:0]);
         default:           draw_en = data[0];
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits of narrow registers get random junk
   function automatic logic [CSR_BITS-1:0] with_junk(input int value, input int width);
      return (CSR_BITS'($urandom) << width) | CSR_BITS'(value);
   endfunction

   task automatic apply_settings(input int hx, input int hy, input int wl, input int wt,
                                 input int wr, input int wb, input mode_type m, input bit en);
      write_reg(CSR_HOTSPOT_X, with_junk(hx, HOT_BITS));
      write_reg(CSR_HOTSPOT_Y, with_junk(hy, HOT_BITS));
      write_reg(CSR_WINDOW_LEFT, CSR_BITS'(wl));
      write_reg(CSR_WINDOW_TOP, CSR_BITS'(wt));
      write_reg(CSR_WINDOW_RIGHT, CSR_BITS'(wr));
      write_reg(CSR_WINDOW_BOTTOM, CSR_BITS'(wb));
      write_reg(CSR_PIXEL_MODE, with_junk(int'(m), 2));
      write_reg(CSR_CURSOR_ENABLE, with_junk(int'(en), 1));
   endtask

   // top rows of the image written up front; the rest fill in as pixels need them
   task automatic test_image_fill();
      req_word_type w;
      gap_max = 3;
      for (int i = 0; i < FILL_WORDS; i++) begin
         w = random_word();
         w.command = CMD_LOAD;
         w.index = IMG_AW'(i);
         send_word(w);
      end
   endtask

   task automatic test_directed_basic();
      gap_max = 0;
      send_word(make_word(CMD_LOAD, 0, 0, 0, 24'h000000, '0));
      send_word(make_word(CMD_LOAD, 0, 0, 33, COLOUR_KEY, '0));
      send_word(make_word(CMD_LOAD, 0, 0, 34, 24'h123456, '0));
      send_word(make_word(CMD_LOAD, 0, 0, 1023, 24'hFFFFFF, '0));
      // on the window's left/top edge: not strictly inside
      send_word(make_word(CMD_PIXEL, 0, 0, 0, '0, 32'h12345678));
      send_word(make_word(CMD_PIXEL, 1, 1, 0, '0, 32'h87654321));
      send_word(make_word(CMD_PIXEL, 2, 1, 0, '0, 32'hA5FFFFFF));
      send_word(make_word(CMD_PIXEL, 31, 31, 0, '0, 32'h00000000));
      send_word(make_word(CMD_PIXEL, 32, 5, 0, '0, 32'hFFFFFFFF));
      send_word(make_word(CMD_NONE, 4095, 4095, 1023, 24'hFFFFFF, 32'hFFFFFFFF));
      // pointer past the bottom-right corner gives an empty rectangle
      send_word(make_word(CMD_MOVE, 4095, 4095, 0, '0, '0));
      send_word(make_word(CMD_PIXEL, 639, 479, 0, '0, 32'h0F0F0F0F));
      send_word(make_word(CMD_MOVE, 0, 0, 0, '0, '0));
      send_word(make_word(CMD_PIXEL, 1, 2, 0, '0, 32'hFFFFFFFF));
   endtask

   task automatic test_directed_clip();
      mode_type sweep [3] = '{MODE_565, MODE_555, MODE_BGR};
      apply_settings(5, 5, 0, 0, 640, 480, MODE_BGRX, 1'b1);
      send_word(make_word(CMD_LOAD, 0, 0, 198, 24'h8899AA, '0));
      // rectangle starts left of and above the screen
      send_word(make_word(CMD_MOVE, 0, 0, 0, '0, '0));
      send_word(make_word(CMD_PIXEL, 1, 1, 0, '0, 32'hFFFFFFFF));
      send_word(make_word(CMD_PIXEL, 26, 26, 0, '0, 32'h5A000000));
      send_word(make_word(CMD_PIXEL, 27, 26, 0, '0, 32'h5A000000));
      foreach (sweep[i]) begin
         write_reg(CSR_PIXEL_MODE, with_junk(int'(sweep[i]), 2));
         send_word(make_word(CMD_PIXEL, 1, 1, 0, '0, 32'hFFFFFFFF));
      end
      // a move while disabled must leave the rectangle where it was
      write_reg(CSR_CURSOR_ENABLE, with_junk(0, 1));
      send_word(make_word(CMD_MOVE, 300, 300, 0, '0, '0));
      send_word(make_word(CMD_PIXEL, 1, 1, 0, '0, 32'hC3C3C3C3));
      write_reg(CSR_CURSOR_ENABLE, with_junk(1, 1));
      send_word(make_word(CMD_PIXEL, 1, 1, 0, '0, 32'hC3C3C3C3));
   endtask

   task automatic test_random_settings();
      int phase_len [7] = '{80, 80, 80, 30, 70, 90, 90};
      int wl, wt;
      for (int ph = 0; ph < 7; ph++) begin
         wl = $urandom_range(0, 600);
         wt = $urandom_range(0, 400);
         case (ph)
            0: apply_settings(0, 0, 0, 0, 640, 480, MODE_BGRX, 1'b1);
            1: apply_settings(31, 31, 0, 0, 4095, 4095, MODE_565, 1'b1);
            2: apply_settings($urandom_range(0, 31), $urandom_range(0, 31), wl, wt,
                              wl + $urandom_range(40, 900), wt + $urandom_range(40, 900),
                              MODE_555, 1'b1);
            3: apply_settings($urandom_range(0, 31), $urandom_range(0, 31), 4095, 4095, 1, 1,
                              MODE_BGR, 1'b1);
            4: apply_settings($urandom_range(0, 31), $urandom_range(0, 31), wl, wt,
                              wl + $urandom_range(40, 900), wt + $urandom_range(40, 900),
                              mode_type'($urandom_range(0, 3)), 1'b0);
            5: apply_settings($urandom_range(0, 31), $urandom_range(0, 31), wl, wt,
                              wl + $urandom_range(40, 3400), wt + $urandom_range(40, 3600),
                              mode_type'($urandom_range(0, 3)), 1'b1);
            default: apply_settings($urandom_range(0, 31), $urandom_range(0, 31),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(1, 4095), $urandom_range(1, 4095),
                                    mode_type'($urandom_range(0, 3)), 1'b1);
         endcase
         case ($urandom_range(0, 2))
            0:       gap_max = 2;
            1:       gap_max = 5;
            default: gap_max = 9;
         endcase
         if (ph == 0) gap_max = 0;
         repeat (phase_len[ph]) send_word(random_word());
      end
   endtask

   // receiver holds off for a long stretch while words keep coming
   task automatic test_backpressure();
      settle();
      gap_max = 0;
      hold_ask <= ~hold_ask;
      repeat (48) send_word(random_word());
   endtask

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(16, 96);
         case ($urandom_range(0, 4))
            0, 1:    stall_pct <= 0;
            2:       stall_pct <= 30;
            3:       stall_pct <= 60;
            default: stall_pct <= 85;
         endcase
      end else begin
         stall_span <= stall_span - 1;
      end
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsp.size() == 0) begin
            $error("result word with nothing outstanding: pixel_out %h cursor_drawn %b",
                   rsp_pixel_out, rsp_cursor_drawn);
            fails++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               $error("pixel_out: expected %h, actual %h", want.pixel, rsp_pixel_out);
               fails++;
            end
            if (rsp_cursor_drawn !== want.drawn) begin
               $error("cursor_drawn: expected %b, actual %b", want.drawn, rsp_cursor_drawn);
               fails++;
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("[color_keyed_cursor_overlay] ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_image_fill();
      test_directed_basic();
      test_directed_clip();
      test_random_settings();
      test_backpressure();
      settle();
      if (expected_rsp.size() != 0) begin
         $error("%0d result words never arrived", expected_rsp.size());
         fails++;
      end
      $display("Covered %0d words (%0d drew the cursor) and %0d register writes:", words_sent,
               words_drawn, csr_writes);
      $display("all pixel modes, window and hotspot extremes, disabled cursor, long hold-off.");
      if (fails == 0) begin
         $display("[color_keyed_cursor_overlay] OK");
      end else begin
         $display("[color_keyed_cursor_overlay] ERROR");
      end
      $finish;
   end

endmodule
